// File: hw/rtl/tlfs_pkg.sv
// Shared types and codes for the two-level preemptive FCFS scheduler.
// Depends on nothing; every other file of the block but tlfs_if.sv imports it.
`default_nettype none

package tlfs_pkg;

	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	localparam logic [2:0] STAT_QUEUED = 3'd0;
	localparam logic [2:0] STAT_FULL   = 3'd1;
	localparam logic [2:0] STAT_ZERO   = 3'd2;
	localparam logic [2:0] STAT_IDLE   = 3'd3;
	localparam logic [2:0] STAT_RAN    = 3'd4;
	localparam logic [2:0] STAT_DONE   = 3'd5;

	typedef struct packed {
		logic [15:0] remaining;
		logic [15:0] burst;
		logic [15:0] arrival;
		logic [15:0] id;
	} job_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/tlfs_if.sv
// Request and response channel interfaces of the scheduler.
// Plain valid/ready handshakes; no package dependency.
`default_nettype none

interface tlfs_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] job_id;
	logic        is_user;
	logic [15:0] burst;

	modport source (output valid, func, job_id, is_user, burst, input ready);
	modport sink (input valid, func, job_id, is_user, burst, output ready);
endinterface

interface tlfs_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] run_id;
	logic [15:0] time_now;
	logic [15:0] turnaround;
	logic [15:0] waiting;

	modport source (output valid, status, run_id, time_now, turnaround, waiting, input ready);
	modport sink (input valid, status, run_id, time_now, turnaround, waiting, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tlfs_queue.sv
// One ready queue: a circular buffer memory with head, tail and fill count.
// Depends on tlfs_pkg for the job record and control/status structs.
`default_nettype none

module tlfs_queue #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tlfs_pkg::q_ctl_t  ctl,
	input  wire tlfs_pkg::job_t    wdata,
	output tlfs_pkg::job_t         rdata_s1,
	output tlfs_pkg::q_stat_t      stat
);
	import tlfs_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= wdata;
		end
		rdata_s1 <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
			end
			if (ctl.pop) begin
				head_q <= (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
			end
			case ({ctl.push, ctl.pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == FULL_CNT);

endmodule

`default_nettype wire

// File: hw/rtl/two_level_preemptive_fcfs_scheduler.sv
// Two-level preemptive FCFS scheduler: a system and a user ready queue, each
// held in a QUEUE_DEPTH x 64 memory with registered read. A request is
// accepted in the idle state, while both queue heads are read; the execute
// state decides, writes the queues back and loads the result register, then
// returns to idle. No new request is taken until the last one is through;
// a waiting result only holds the execute state.
// Queue contents are not cleared at reset.
`default_nettype none

module two_level_preemptive_fcfs_scheduler #(
	parameter int unsigned QUEUE_DEPTH = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tlfs_req_if.sink   req,
	tlfs_rsp_if.source rsp
);
	import tlfs_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic        state_q;
	logic        func_q;
	logic [15:0] job_id_q;
	logic        is_user_q;
	logic [15:0] burst_q;

	logic [15:0] clock_q;
	job_t        run_job_q;
	logic        run_valid_q;
	logic        run_user_q;

	logic        rsp_valid_q;
	logic [2:0]  rsp_status_q;
	logic [15:0] rsp_run_id_q;
	logic [15:0] rsp_time_q;
	logic [15:0] rsp_tat_q;
	logic [15:0] rsp_wt_q;

	q_ctl_t  sys_ctl, usr_ctl;
	q_stat_t sys_stat, usr_stat;
	job_t    sys_wdata, usr_wdata, sys_rdata, usr_rdata;

	logic        exec_go;
	logic        preempt;
	logic        have_job;
	job_t        arr_rec;
	job_t        cur_job;
	job_t        nxt_job;
	logic        nxt_valid;
	logic        nxt_user;
	logic [15:0] nxt_clock;
	logic [15:0] rem;
	logic [2:0]  st_status;
	logic [15:0] st_run_id;
	logic [15:0] st_time;
	logic [15:0] st_tat;
	logic [15:0] st_wt;

	tlfs_queue #(.DEPTH(QUEUE_DEPTH)) u_sys_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sys_ctl),
		.wdata    (sys_wdata),
		.rdata_s1 (sys_rdata),
		.stat     (sys_stat)
	);

	tlfs_queue #(.DEPTH(QUEUE_DEPTH)) u_usr_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (usr_ctl),
		.wdata    (usr_wdata),
		.rdata_s1 (usr_rdata),
		.stat     (usr_stat)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign exec_go   = (state_q == ST_EXEC) && (!rsp_valid_q || rsp.ready);
	assign arr_rec   = '{remaining: burst_q, burst: burst_q, arrival: clock_q, id: job_id_q};

	always_comb begin
		sys_ctl   = '0;
		usr_ctl   = '0;
		sys_wdata = arr_rec;
		usr_wdata = arr_rec;
		preempt   = 1'b0;
		have_job  = 1'b0;
		cur_job   = run_job_q;
		nxt_job   = run_job_q;
		nxt_valid = run_valid_q;
		nxt_user  = run_user_q;
		nxt_clock = clock_q;
		rem       = '0;
		st_status = STAT_IDLE;
		st_run_id = '0;
		st_time   = clock_q;
		st_tat    = '0;
		st_wt     = '0;
		if (func_q == FUNC_ARRIVE) begin
			if (burst_q == '0) begin
				st_status = STAT_ZERO;
			end else if (is_user_q ? usr_stat.full : sys_stat.full) begin
				st_status = STAT_FULL;
			end else begin
				st_status = STAT_QUEUED;
				if (is_user_q) begin
					usr_ctl.push = exec_go;
				end else begin
					sys_ctl.push = exec_go;
				end
			end
		end else begin
			nxt_clock = clock_q + 16'd1;
			st_time   = nxt_clock;
			preempt   = run_valid_q && run_user_q && !sys_stat.empty && !usr_stat.full;
			if (preempt) begin
				usr_ctl.push = exec_go;
				usr_wdata    = run_job_q;
			end
			if (run_valid_q && !preempt) begin
				have_job = 1'b1;
			end else if (!sys_stat.empty) begin
				cur_job     = sys_rdata;
				sys_ctl.pop = exec_go;
				nxt_user    = 1'b0;
				have_job    = 1'b1;
			end else if (!usr_stat.empty) begin
				cur_job     = usr_rdata;
				usr_ctl.pop = exec_go;
				nxt_user    = 1'b1;
				have_job    = 1'b1;
			end
			if (have_job) begin
				rem               = cur_job.remaining - 16'd1;
				st_run_id         = cur_job.id;
				nxt_job           = cur_job;
				nxt_job.remaining = rem;
				if (rem == '0) begin
					st_tat    = nxt_clock - cur_job.arrival;
					st_wt     = st_tat - cur_job.burst;
					st_status = STAT_DONE;
					nxt_valid = 1'b0;
				end else begin
					st_status = STAT_RAN;
					nxt_valid = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clock_q     <= '0;
			run_valid_q <= 1'b0;
			run_user_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (exec_go) begin
				clock_q     <= nxt_clock;
				run_valid_q <= nxt_valid;
				run_user_q  <= nxt_user;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q    <= req.func;
			job_id_q  <= req.job_id;
			is_user_q <= req.is_user;
			burst_q   <= req.burst;
		end
		if (exec_go) begin
			run_job_q    <= nxt_job;
			rsp_status_q <= st_status;
			rsp_run_id_q <= st_run_id;
			rsp_time_q   <= st_time;
			rsp_tat_q    <= st_tat;
			rsp_wt_q     <= st_wt;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.run_id     = rsp_run_id_q;
	assign rsp.time_now   = rsp_time_q;
	assign rsp.turnaround = rsp_tat_q;
	assign rsp.waiting    = rsp_wt_q;

endmodule

`default_nettype wire

// File: hw/rtl/tlfs_checker.sv
// Port-level assertions for the scheduler and the bind that attaches them.
// Depends on tlfs_pkg for the status codes.
`default_nettype none

module tlfs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [2:0]  status,
	input wire logic [15:0] run_id,
	input wire logic [15:0] turnaround,
	input wire logic [15:0] waiting
);
	import tlfs_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(run_id))
		else $error("Stalled response changed.");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status <= STAT_DONE)
		else $error("Response status out of range.");

	a_times_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STAT_DONE |-> turnaround == '0 && waiting == '0)
		else $error("Turnaround or waiting set on an unfinished result.");

	a_no_run_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STAT_QUEUED || status == STAT_FULL ||
			status == STAT_ZERO || status == STAT_IDLE) |-> run_id == '0)
		else $error("Run id set on a result where no job ran.");

	a_req_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Request accepted in back-to-back cycles.");

endmodule

bind two_level_preemptive_fcfs_scheduler tlfs_checker u_tlfs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.run_id     (rsp.run_id),
	.turnaround (rsp.turnaround),
	.waiting    (rsp.waiting)
);

`default_nettype wire
